FILE: rtl/wtrms_pkg.sv
// Shared constants, status codes and the front-to-back job record for the
// windowed trapezoidal RMS block. No dependencies.

package wtrms_pkg;

  localparam int TIME_BITS   = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
  localparam int AREA_BITS   = 64;
  localparam int RMS_BITS    = 16;
  localparam int REG_BITS    = 32;
  localparam int ADDR_BITS   = 3;

  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int QCNT_BITS   = $clog2(QDEPTH + 3);

  localparam int DIV_STEPS   = AREA_BITS;
  localparam int SQRT_STEPS  = AREA_BITS / 2;
  localparam int DCNT_BITS   = $clog2(DIV_STEPS);
  localparam int SCNT_BITS   = $clog2(SQRT_STEPS);

  // Register index, taken from paddr[2]
  localparam logic REG_WINDOW_START = 1'b0;
  localparam logic REG_WINDOW_END   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SAT   = 2'd2,
    ST_DEC   = 2'd3
  } status_t;

  typedef struct packed {
    status_t                status;
    logic [AREA_BITS-1:0]   area;
    logic [TIME_BITS-1:0]   span;
  } job_t;

endpackage

FILE: rtl/wtrms_if.sv
// Valid/ready channels for samples and results of the RMS block.
// Depends on wtrms_pkg.

interface wtrms_sample_if import wtrms_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [TIME_BITS-1:0]          sample_time;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          end_of_wave;

  modport source (output valid, sample_time, sample_value, end_of_wave, input ready);
  modport sink   (input valid, sample_time, sample_value, end_of_wave, output ready);
endinterface

interface wtrms_result_if import wtrms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RMS_BITS-1:0] rms_value;
  logic [1:0]          status;

  modport source (output valid, rms_value, status, input ready);
  modport sink   (input valid, rms_value, status, output ready);
endinterface

FILE: rtl/wtrms_regs.sv
// APB register file holding the measurement window.
// Depends on wtrms_pkg.

module wtrms_regs import wtrms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [REG_BITS-1:0]  pwdata,
  output logic [REG_BITS-1:0]  prdata,
  output logic                 pready,
  output logic [TIME_BITS-1:0] window_start,
  output logic [TIME_BITS-1:0] window_end
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end   <= '1;
    end else if (wr) begin
      if (paddr[2] == REG_WINDOW_END) begin
        window_end <= pwdata[TIME_BITS-1:0];
      end else begin
        window_start <= pwdata[TIME_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW_END) ? REG_BITS'(window_end)
                                               : REG_BITS'(window_start);

endmodule

FILE: rtl/wtrms_front.sv
// Front end: classifies samples against the window and integrates value
// squared in three stages, pushing one job per waveform. Depends on wtrms_pkg.

module wtrms_front import wtrms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  wtrms_sample_if.sink         samples,
  input  logic [TIME_BITS-1:0] window_start,
  input  logic [TIME_BITS-1:0] window_end,
  input  logic [QCNT_BITS-1:0] q_level,
  output logic                 push,
  output job_t                 push_data
);

  // Stage 1 state: ordering and window tracking
  logic                 seen_any;
  logic [TIME_BITS-1:0] last_time;
  logic                 seen_first;
  logic [TIME_BITS-1:0] first_time;
  logic [TIME_BITS-1:0] previous_time;
  logic                 dec_flag;

  // Stage 2 state
  logic [SQ_BITS-1:0]   previous_square;

  // Stage 3 state
  logic [AREA_BITS-1:0] double_area;
  logic                 sat_flag;

  // Pipeline registers
  logic                   v1, last1, integ1, upd1, dec1;
  logic [SQ_BITS-1:0]     sq1;
  logic [TIME_BITS-1:0]   dt1, span1;
  logic                   v2, last2, dec2;
  logic [AREA_BITS-1:0]   term2;
  logic [TIME_BITS-1:0]   span2;

  logic                   fire;
  logic                   dec, inwin;
  logic [SAMPLE_BITS-1:0] raw, mag;
  logic [2*SAMPLE_BITS-1:0] sq_full;
  logic                   seen_first_next;
  logic [TIME_BITS-1:0]   first_time_next, previous_time_next, span;
  logic [QCNT_BITS-1:0]   pending;

  logic [2*SAMPLE_BITS-1:0]           sq_sum;
  logic [2*SAMPLE_BITS+TIME_BITS-1:0] prod;
  logic [AREA_BITS:0]                 area_sum;
  logic                               sat_now, sat_next;
  logic [AREA_BITS-1:0]               area_next;
  status_t                            push_status;

  // Hold input while the queue could not take every end-of-wave in flight
  assign pending = q_level + QCNT_BITS'(v1 && last1) + QCNT_BITS'(v2 && last2);
  assign samples.ready = pending < QCNT_BITS'(QDEPTH);
  assign fire = samples.valid && samples.ready;

  assign raw     = samples.sample_value;
  assign mag     = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
  assign sq_full = mag * mag;

  assign dec   = seen_any && (samples.sample_time < last_time);
  assign inwin = !dec && (samples.sample_time >= window_start)
                      && (samples.sample_time <= window_end);

  always_comb begin
    seen_first_next    = seen_first;
    first_time_next    = first_time;
    previous_time_next = previous_time;
    if (inwin) begin
      seen_first_next    = 1'b1;
      previous_time_next = samples.sample_time;
      if (!seen_first) begin
        first_time_next = samples.sample_time;
      end
    end
    span = seen_first_next ? (previous_time_next - first_time_next) : '0;
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      seen_any      <= 1'b0;
      last_time     <= '0;
      seen_first    <= 1'b0;
      first_time    <= '0;
      previous_time <= '0;
      dec_flag      <= 1'b0;
    end else begin
      v1 <= fire;
      if (fire) begin
        if (samples.end_of_wave) begin
          seen_any      <= 1'b0;
          last_time     <= '0;
          seen_first    <= 1'b0;
          first_time    <= '0;
          previous_time <= '0;
          dec_flag      <= 1'b0;
        end else begin
          seen_any      <= 1'b1;
          last_time     <= samples.sample_time;
          seen_first    <= seen_first_next;
          first_time    <= first_time_next;
          previous_time <= previous_time_next;
          dec_flag      <= dec_flag || dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      last1  <= samples.end_of_wave;
      integ1 <= inwin && seen_first;
      upd1   <= inwin;
      dec1   <= dec_flag || dec;
      sq1    <= sq_full[SQ_BITS-1:0];
      dt1    <= samples.sample_time - previous_time;
      span1  <= span;
    end
  end

  // Stage 2: trapezoid term
  assign sq_sum = {1'b0, previous_square} + {1'b0, sq1};
  assign prod   = sq_sum * dt1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2              <= 1'b0;
      previous_square <= '0;
    end else begin
      v2 <= v1;
      if (v1) begin
        if (last1) begin
          previous_square <= '0;
        end else if (upd1) begin
          previous_square <= sq1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      last2 <= last1;
      dec2  <= dec1;
      span2 <= span1;
      term2 <= integ1 ? AREA_BITS'(prod) : '0;
    end
  end

  // Stage 3: saturating accumulate
  assign area_sum  = {1'b0, double_area} + {1'b0, term2};
  assign sat_now   = area_sum[AREA_BITS];
  assign area_next = sat_now ? '1 : area_sum[AREA_BITS-1:0];
  assign sat_next  = sat_flag || sat_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      double_area <= '0;
      sat_flag    <= 1'b0;
    end else if (v2) begin
      if (last2) begin
        double_area <= '0;
        sat_flag    <= 1'b0;
      end else begin
        double_area <= area_next;
        sat_flag    <= sat_next;
      end
    end
  end

  always_comb begin
    if (dec2) begin
      push_status = ST_DEC;
    end else if (span2 == '0) begin
      push_status = ST_EMPTY;
    end else if (sat_next) begin
      push_status = ST_SAT;
    end else begin
      push_status = ST_OK;
    end
  end

  assign push      = v2 && last2;
  assign push_data = {push_status, area_next, span2};

endmodule

FILE: rtl/wtrms_queue.sv
// Small job queue between front and back ends, built from flip-flops.
// Depends on wtrms_pkg.

module wtrms_queue import wtrms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  job_t                 push_data,
  input  logic                 pop,
  output job_t                 pop_data,
  output logic                 not_empty,
  output logic [QCNT_BITS-1:0] level
);

  job_t                 entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign pop_data  = entries[rd_ptr];
  assign not_empty = level != '0;

endmodule

FILE: rtl/wtrms_back.sv
// Back end: bit-serial divide of the area by twice the span, then a
// digit-by-digit square root, into a result register. Depends on wtrms_pkg.

module wtrms_back import wtrms_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_not_empty,
  input  job_t           q_data,
  output logic           pop,
  wtrms_result_if.source results
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SQRT
  } state_t;

  state_t                 state;
  logic [AREA_BITS-1:0]   dq;
  logic [TIME_BITS+1:0]   rem;
  logic [TIME_BITS+1:0]   divisor;
  logic [DCNT_BITS-1:0]   dcnt;
  logic [AREA_BITS-1:0]   x, res, sbit;
  logic [SCNT_BITS-1:0]   scnt;
  logic                   out_valid;
  logic [RMS_BITS-1:0]    out_rms;
  status_t                out_status;

  logic [TIME_BITS+1:0]   rem_sh;
  logic                   ge;
  logic [AREA_BITS-1:0]   dq_next, rb;
  logic                   take;
  logic [AREA_BITS-1:0]   res_next;

  assign rem_sh  = {rem[TIME_BITS:0], dq[AREA_BITS-1]};
  assign ge      = rem_sh >= divisor;
  assign dq_next = {dq[AREA_BITS-2:0], ge};

  assign rb       = res + sbit;
  assign take     = x >= rb;
  assign res_next = take ? ((res >> 1) + sbit) : (res >> 1);

  assign pop = (state == S_IDLE) && q_not_empty && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            if (q_data.status == ST_OK) begin
              dq      <= q_data.area;
              rem     <= '0;
              divisor <= {1'b0, q_data.span, 1'b0};
              dcnt    <= DCNT_BITS'(DIV_STEPS - 1);
              state   <= S_DIV;
            end else begin
              out_rms    <= '0;
              out_status <= q_data.status;
              out_valid  <= 1'b1;
            end
          end
        end
        S_DIV: begin
          rem  <= ge ? (rem_sh - divisor) : rem_sh;
          dq   <= dq_next;
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            x     <= dq_next;
            res   <= '0;
            sbit  <= AREA_BITS'(1) << (AREA_BITS - 2);
            scnt  <= SCNT_BITS'(SQRT_STEPS - 1);
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (take) begin
            x <= x - rb;
          end
          res  <= res_next;
          sbit <= sbit >> 2;
          scnt <= scnt - 1'b1;
          if (scnt == '0) begin
            out_rms    <= (res_next[AREA_BITS-1:RMS_BITS] != '0) ? '1
                                                                 : res_next[RMS_BITS-1:0];
            out_status <= ST_OK;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid     = out_valid;
  assign results.rms_value = out_rms;
  assign results.status    = out_status;

endmodule

FILE: rtl/windowed_trapezoid_rms.sv
// Top level of the windowed trapezoidal RMS measurement.
// Depends on wtrms_pkg, wtrms_if, wtrms_regs, wtrms_front, wtrms_queue, wtrms_back.

// Samples (time, signed value, end-of-wave mark) enter on the samples channel
// at up to one per cycle; those inside [window_start, window_end] build twice
// the trapezoidal area of value squared, saturating at 64 bits. On the
// end-of-wave sample one result leaves on the results channel: the floor of
// sqrt(area / (2 * span)) with status 0, or rms 0 with status 3 (time went
// backwards), 1 (fewer than two in-window samples or zero span) or 2 (area
// saturated), in that priority. The three-stage front end runs at one sample
// per cycle and hands one job per waveform to a four-entry queue. The back
// end takes one job at a time: a one-bit-per-cycle divider and a
// two-bits-per-cycle square root set its cost for an ok result, while an
// error result skips both. Input stalls only when four results are queued
// or in flight behind a slow consumer or a burst of short waveforms. Write
// the window registers over APB (offset 0 start, 4 end) only while idle.

module windowed_trapezoid_rms import wtrms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  wtrms_sample_if.sink         samples,
  wtrms_result_if.source       results,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [REG_BITS-1:0]  pwdata,
  output logic [REG_BITS-1:0]  prdata,
  output logic                 pready
);

  logic [TIME_BITS-1:0] window_start;
  logic [TIME_BITS-1:0] window_end;
  logic                 push, pop, q_not_empty;
  job_t                 push_data, q_data;
  logic [QCNT_BITS-1:0] q_level;

  // Window registers
  wtrms_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .window_start (window_start),
    .window_end   (window_end)
  );

  // Classify and integrate; advance every cycle, hold input on queue credit
  wtrms_front u_front (
    .clk          (clk),
    .rst          (rst),
    .samples      (samples),
    .window_start (window_start),
    .window_end   (window_end),
    .q_level      (q_level),
    .push         (push),
    .push_data    (push_data)
  );

  // Decouple per-waveform jobs from the slow divide and root
  wtrms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  // Divide, take the root, hold the result until taken
  wtrms_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .pop         (pop),
    .results     (results)
  );

endmodule
